@@ src/lzw_variable_width_encoder_assert.svh @@
// Assertion macros used by the encoder.
`ifndef LZW_VARIABLE_WIDTH_ENCODER_ASSERT_SVH
`define LZW_VARIABLE_WIDTH_ENCODER_ASSERT_SVH
// Asserts that a condition implies a consequence in the same cycle.
`define LZW_ASSERT_IMPL(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");
// Asserts that a condition implies a consequence in the next cycle.
`define LZW_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ src/lzw_pkg.sv @@
`default_nettype none
package lzw_pkg;
   localparam int TableSlotsDef = 5021;
   localparam int MaxBitsDef = 12;
   localparam logic [11:0] CodeEnd = 12'd256;
   localparam logic [11:0] CodeWiden = 12'd257;
   localparam logic [11:0] CodeFlush = 12'd258;
   localparam logic [12:0] CodeFirst = 13'd259;
   localparam logic [3:0] StartWidth = 4'd9;
   localparam logic [11:0] StartLimit = 12'd511;
endpackage
`default_nettype wire

@@ src/lzw_if.sv @@
`default_nettype none
interface lzw_req_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic block_end;
   modport source (output valid, data_byte, block_end, input ready);
   modport sink (input valid, data_byte, block_end, output ready);
endinterface

interface lzw_rsp_if;
   logic valid;
   logic ready;
   logic [11:0] code_word;
   logic [3:0] code_width;
   logic run_last;
   modport source (output valid, code_word, code_width, run_last, input ready);
   modport sink (input valid, code_word, code_width, run_last, output ready);
endinterface
`default_nettype wire

@@ src/lzw_ram.sv @@
`default_nettype none
module lzw_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(Depth)-1:0] wr_addr,
   input wire logic [Width-1:0] wr_data,
   input wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ src/lzw_variable_width_encoder.sv @@
// Each byte passes through a hash state and an index reduction state, then one or more
// dictionary probes, each through issue, read and compare states, as the slot memory has a
// single read port. A byte that misses queues its results, which the emit state moves to the
// output register one at a time while that register is free or being read, and a block end
// first queues the final codes in the emit state. The first byte of a block goes from the
// hash state straight to the emit state. Results leave through a one-entry output register,
// up to four per byte. After reset and after each flush or block end, a clearing pass writes
// one slot per cycle over all TABLE_SLOTS slots, during which no byte is accepted.
`default_nettype none
`include "lzw_variable_width_encoder_assert.svh"
module lzw_variable_width_encoder #(
   parameter int TABLE_SLOTS = lzw_pkg::TableSlotsDef,
   parameter int MAX_BITS = lzw_pkg::MaxBitsDef
) (
   input wire logic clock,
   input wire logic reset,
   lzw_req_if.sink req,
   lzw_rsp_if.source rsp
);
   import lzw_pkg::*;
   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int SW = AW + 1;
   localparam logic [12:0] TopCode = 13'((1 << MAX_BITS) - 1);
   localparam logic [AW-1:0] LastSlot = AW'(TABLE_SLOTS - 1);
   localparam logic [SW-1:0] Slots = SW'(TABLE_SLOTS);
   localparam int EW = 1 + 12 + 12 + 8;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HASH, S_RED, S_ISSUE, S_READ, S_CMP, S_EMIT
   } state_type;

   state_type state_ff;
   logic [AW-1:0] clr_ff, idx_ff, off_ff;
   logic [12:0] hsh_ff;
   logic [SW-1:0] cnt_ff;
   logic [7:0] byte_ff;
   logic last_ff;
   logic [11:0] prefix_ff;
   logic have_ff;
   logic [12:0] nfc_ff;
   logic [3:0] width_ff;
   logic [11:0] limit_ff;
   logic [11:0] q_code_ff [4];
   logic [3:0] q_width_ff [4];
   logic [2:0] q_n_ff, q_i_ff;
   logic clr_after_ff;
   logic ov_ff;
   logic [11:0] ov_code_ff;
   logic [3:0] ov_width_ff;
   logic ov_last_ff;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;

   lzw_ram #(.Width(EW), .Depth(TABLE_SLOTS)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic r_used;
   logic [11:0] r_code, r_pfx;
   logic [7:0] r_byte;
   assign {r_used, r_code, r_pfx, r_byte} = rd_data;
   assign rd_addr = idx_ff;

   logic out_free;
   logic ov_load;
   assign out_free = !ov_ff || rsp.ready;
   assign ov_load = (state_ff == S_EMIT) && !last_ff && (q_i_ff != q_n_ff) && out_free;
   assign rsp.valid = ov_ff;
   assign rsp.code_word = ov_code_ff;
   assign rsp.code_width = ov_width_ff;
   assign rsp.run_last = ov_last_ff;
   assign req.ready = (state_ff == S_IDLE);

   logic miss_store;
   always_comb begin
      wr_en = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      miss_store = (state_ff == S_CMP) && !r_used;
      if (state_ff == S_CLEAR) begin
         wr_en = 1'b1;
      end else if (miss_store) begin
         wr_en = 1'b1;
         wr_addr = idx_ff;
         wr_data = {1'b1, nfc_ff[11:0], prefix_ff, byte_ff};
      end
   end

   logic [12:0] nfc_inc;
   logic [AW-1:0] idx_step;
   assign nfc_inc = nfc_ff + 13'd1;
   assign idx_step = (idx_ff >= off_ff) ? idx_ff - off_ff
                                        : AW'(SW'(idx_ff) + Slots - SW'(off_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         ov_ff <= 1'b0;
         have_ff <= 1'b0;
         prefix_ff <= '0;
         nfc_ff <= CodeFirst;
         width_ff <= StartWidth;
         limit_ff <= StartLimit;
         q_n_ff <= '0;
         q_i_ff <= '0;
         clr_after_ff <= 1'b0;
      end else begin
         if (ov_load) ov_ff <= 1'b1;
         else if (rsp.ready) ov_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               if (clr_ff == LastSlot) begin
                  clr_ff <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  clr_ff <= clr_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (req.valid) begin
                  byte_ff <= req.data_byte;
                  last_ff <= req.block_end;
                  q_n_ff <= '0;
                  q_i_ff <= '0;
                  clr_after_ff <= 1'b0;
                  state_ff <= S_HASH;
                  hsh_ff <= 13'(({4'd0, req.data_byte} << (MAX_BITS - 8)) ^ {1'b0, prefix_ff});
               end
            end
            S_HASH: begin
               if (!have_ff) begin
                  prefix_ff <= {4'd0, byte_ff};
                  have_ff <= 1'b1;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_RED;
               end
            end
            S_RED: begin
               logic [AW-1:0] ix;
               ix = (hsh_ff >= 13'(TABLE_SLOTS)) ? AW'(hsh_ff - 13'(TABLE_SLOTS))
                                                 : AW'(hsh_ff);
               idx_ff <= ix;
               off_ff <= (ix == '0) ? AW'(1) : AW'(Slots - SW'(ix));
               cnt_ff <= '0;
               state_ff <= S_ISSUE;
            end
            S_ISSUE: state_ff <= S_READ;
            S_READ: state_ff <= S_CMP;
            S_CMP: begin
               logic hit, miss;
               hit = r_used && r_pfx == prefix_ff && r_byte == byte_ff;
               miss = !r_used || (!hit && cnt_ff == Slots - 1'b1);
               if (hit) begin
                  prefix_ff <= r_code;
                  state_ff <= S_EMIT;
               end else if (miss) begin
                  prefix_ff <= {4'd0, byte_ff};
                  q_code_ff[0] <= prefix_ff;
                  q_width_ff[0] <= width_ff;
                  if (nfc_inc > TopCode) begin
                     q_code_ff[1] <= CodeFlush;
                     q_width_ff[1] <= width_ff;
                     q_n_ff <= 3'd2;
                     nfc_ff <= CodeFirst;
                     width_ff <= StartWidth;
                     limit_ff <= StartLimit;
                     clr_after_ff <= 1'b1;
                  end else if (nfc_inc > {1'b0, limit_ff}) begin
                     q_code_ff[1] <= CodeWiden;
                     q_width_ff[1] <= width_ff;
                     q_n_ff <= 3'd2;
                     nfc_ff <= nfc_inc;
                     width_ff <= width_ff + 4'd1;
                     limit_ff <= {limit_ff[10:0], 1'b1};
                  end else begin
                     q_n_ff <= 3'd1;
                     nfc_ff <= nfc_inc;
                  end
                  state_ff <= S_EMIT;
               end else begin
                  idx_ff <= idx_step;
                  cnt_ff <= cnt_ff + 1'b1;
                  state_ff <= S_ISSUE;
               end
            end
            S_EMIT: begin
               if (last_ff) begin
                  q_code_ff[q_n_ff[1:0]] <= prefix_ff;
                  q_width_ff[q_n_ff[1:0]] <= width_ff;
                  q_code_ff[2'(q_n_ff + 3'd1)] <= CodeEnd;
                  q_width_ff[2'(q_n_ff + 3'd1)] <= width_ff;
                  q_n_ff <= q_n_ff + 3'd2;
                  last_ff <= 1'b0;
                  have_ff <= 1'b0;
                  prefix_ff <= '0;
                  nfc_ff <= CodeFirst;
                  width_ff <= StartWidth;
                  limit_ff <= StartLimit;
                  clr_after_ff <= 1'b1;
               end else if (q_i_ff == q_n_ff) begin
                  state_ff <= clr_after_ff ? S_CLEAR : S_IDLE;
               end else if (out_free) begin
                  ov_code_ff <= q_code_ff[q_i_ff[1:0]];
                  ov_width_ff <= q_width_ff[q_i_ff[1:0]];
                  ov_last_ff <= (q_i_ff + 3'd1 == q_n_ff);
                  q_i_ff <= q_i_ff + 3'd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `LZW_ASSERT_IMPL(a_ready_idle, clock, reset, req.ready, state_ff == S_IDLE && !wr_en)
   `LZW_ASSERT_IMPL(a_queue_bound, clock, reset, 1'b1, q_n_ff <= 3'd4 && q_i_ff <= q_n_ff)
   `LZW_ASSERT_NEXT(a_out_hold, clock, reset, rsp.valid && !rsp.ready,
      rsp.valid && $stable(rsp.code_word))
endmodule
`default_nettype wire

@@ tb/lzw_encoder_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module lzw_encoder_checker (
   input wire logic clock,
   input wire logic reset,
   lzw_req_if req,
   lzw_rsp_if rsp,
   output int fail_count,
   output int pending_codes
);
   import lzw_pkg::*;

   typedef struct packed {
      logic [11:0] code_word;
      logic [3:0] code_width;
      logic run_last;
   } code_type;

   code_type expected_codes[$];

   logic [11:0] dict_code[TableSlotsDef];
   logic [11:0] dict_prefix[TableSlotsDef];
   logic [7:0] dict_byte[TableSlotsDef];
   logic dict_used[TableSlotsDef];
   logic [11:0] cur_prefix;
   logic prefix_valid;
   logic [12:0] free_code;
   logic [3:0] cur_width;
   logic [11:0] grow_limit;
   int mismatches;

   function automatic void clear_dict();
      for (int i = 0; i < TableSlotsDef; i++) dict_used[i] = 1'b0;
      free_code = CodeFirst;
      cur_width = StartWidth;
      grow_limit = StartLimit;
   endfunction

   function automatic int find_slot(input logic [11:0] pfx, input logic [7:0] b);
      int idx;
      int off;
      idx = ((int'(b) << (MaxBitsDef - 8)) ^ int'(pfx)) % TableSlotsDef;
      off = (idx == 0) ? 1 : TableSlotsDef - idx;
      for (int n = 0; n < TableSlotsDef; n++) begin
         if (!dict_used[idx]) return idx;
         if (dict_prefix[idx] == pfx && dict_byte[idx] == b) return idx;
         if (idx >= off) idx = idx - off;
         else idx = idx + TableSlotsDef - off;
      end
      return -1;
   endfunction

   function automatic void emit_code(input logic [11:0] code, inout code_type batch[$]);
      code_type c;
      c.code_word = code;
      c.code_width = cur_width;
      c.run_last = 1'b0;
      batch.push_back(c);
   endfunction

   function automatic void encode_byte(input logic [7:0] b, input logic last);
      code_type batch[$];
      int s;
      if (!prefix_valid) begin
         cur_prefix = {4'd0, b};
         prefix_valid = 1'b1;
      end else begin
         s = find_slot(cur_prefix, b);
         if (s >= 0 && dict_used[s]) begin
            cur_prefix = dict_code[s];
         end else begin
            if (s >= 0) begin
               dict_used[s] = 1'b1;
               dict_code[s] = free_code[11:0];
               dict_prefix[s] = cur_prefix;
               dict_byte[s] = b;
            end
            free_code = free_code + 13'd1;
            emit_code(cur_prefix, batch);
            cur_prefix = {4'd0, b};
            if (free_code > 13'((1 << MaxBitsDef) - 1)) begin
               emit_code(CodeFlush, batch);
               clear_dict();
            end else if (free_code > {1'b0, grow_limit}) begin
               emit_code(CodeWiden, batch);
               cur_width = cur_width + 4'd1;
               grow_limit = {grow_limit[10:0], 1'b1};
            end
         end
      end
      if (last) begin
         emit_code(cur_prefix, batch);
         emit_code(CodeEnd, batch);
         prefix_valid = 1'b0;
         cur_prefix = 12'd0;
         clear_dict();
      end
      if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
      foreach (batch[i]) expected_codes.push_back(batch[i]);
   endfunction

   always @(posedge clock) begin
      code_type got;
      code_type want;
      if (reset) begin
         clear_dict();
         cur_prefix = 12'd0;
         prefix_valid = 1'b0;
         expected_codes.delete();
         fail_count = 0;
         mismatches = 0;
      end else begin
         if (req.valid && req.ready) encode_byte(req.data_byte, req.block_end);
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.code_word, rsp.code_width, rsp.run_last};
            if (expected_codes.size() == 0) begin
               fail_count++;
               if (mismatches < 10)
                  $display("Unexpected code transfer: code %0d width %0d last %0b",
                     got.code_word, got.code_width, got.run_last);
               mismatches++;
            end else begin
               want = expected_codes.pop_front();
               if (got != want) begin
                  fail_count++;
                  if (mismatches < 10)
                     $display("Code mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                        want.code_word, want.code_width, want.run_last,
                        got.code_word, got.code_width, got.run_last);
                  mismatches++;
               end
            end
         end
      end
      pending_codes = expected_codes.size();
   end
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   logic clock = 1'b0;
   logic reset = 1'b1;
   int fail_count;
   int pending_codes;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int items_left;
   int block_len;
   int alphabet;

   lzw_req_if req ();
   lzw_rsp_if rsp ();

   lzw_variable_width_encoder uut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   lzw_encoder_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .fail_count(fail_count),
      .pending_codes(pending_codes)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 20000000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp.ready <= (reset == 1'b0) && ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic transfer_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid = 1'b1;
      req.data_byte = b;
      req.block_end = last;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   task automatic random_block(input int len);
      logic [7:0] b;
      alphabet = $urandom_range(0, 2);
      for (int i = 0; i < len; i++) begin
         case (alphabet)
            0: b = 8'($urandom_range(0, 3));
            1: b = 8'($urandom_range(0, 15)) ^ 8'hF0;
            default: b = 8'($urandom);
         endcase
         transfer_byte(b, i == len - 1);
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.data_byte = 8'd0;
      req.block_end = 1'b0;
      rsp.ready = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      transfer_byte(8'h00, 1'b1);
      transfer_byte(8'hFF, 1'b1);
      for (int i = 0; i < 8; i++) transfer_byte(8'hFF, i == 7);
      for (int i = 0; i < 8; i++) transfer_byte((i % 2) ? 8'h00 : 8'hFF, i == 7);
      for (int i = 0; i < 6; i++) transfer_byte(8'h55 << (i % 2), i == 5);

      for (int i = 0; i < 290; i++) transfer_byte(8'($urandom), i == 289);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 80; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 80; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         items_left = 25;
         while (items_left > 0) begin
            block_len = $urandom_range(1, 30);
            if (block_len > items_left) block_len = items_left;
            random_block(block_len);
            items_left -= block_len;
         end
      end

      while (pending_codes != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
